[design/ray_box_slab_test_defines.svh]
// ------------------------------------------------------------------------
// ray_box_slab_test_defines
// Assertion macros shared by the slab test modules. They expand to nothing
// when SYNTHESIS is defined.
// ------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RBS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define RBS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBS_ASSERT(name, prop, msg)
`define RBS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[design/rbs_pkg.sv]
// ------------------------------------------------------------------------
// rbs_pkg
// Request and result types, controller commands and time constants for
// the ray versus box slab test.
// ------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

	localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               first_axis;
		logic               last_axis;
		logic signed [31:0] axis_origin;
		logic signed [31:0] axis_direction;
		logic signed [31:0] slab_min;
		logic signed [31:0] slab_max;
		logic signed [31:0] start_t_min;
		logic signed [31:0] start_t_max;
	} ray_req_t;

	typedef struct packed {
		logic               still_hit;
		logic               done_res;
		logic signed [31:0] enter_time;
		logic signed [31:0] exit_time;
	} ray_res_t;

	typedef struct packed {
		logic load;       // capture request, seed interval
		logic prep;       // form slab minus origin
		logic sel;        // 0: slab_min, 1: slab_max
		logic div_start;
		logic save_t0;
		logic order;      // order entry and exit times
		logic narrow;     // update running interval
		logic finish;     // load result register
	} rbs_cmd_t;

	typedef struct packed {
		logic dir_zero;
		logic div_done;
	} rbs_sts_t;

endpackage

`default_nettype wire

[design/rbs_div.sv]
// ------------------------------------------------------------------------
// rbs_div
// Serial restoring divider, one quotient bit a cycle. Divides
// num_mag * 2^FRAC_BITS by den_mag; quotients of 2^32 or more raise ovf.
// ------------------------------------------------------------------------
`default_nettype none
`include "ray_box_slab_test_defines.svh"

module rbs_div #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num_mag,
	input  wire logic [31:0] den_mag,
	output logic             busy,
	output logic             done,
	output logic [31:0]      quo,
	output logic             ovf
);

	localparam int unsigned STEPS = 32;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          rem_q;
	logic [31:0]          num_q;
	logic [31:0]          den_q;
	logic [31:0]          quo_q;
	logic                 ovf_q;
	logic [FRAC_BITS-1:0] num_top;
	logic [31:0]          top_ext;
	logic [32:0]          trial;

	// bits shifted above bit 31 form the starting remainder
	assign num_top = num_mag[31 -: FRAC_BITS];
	assign top_ext = 32'(num_top);
	assign trial   = {rem_q, num_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= top_ext;
			num_q <= {num_mag[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
			den_q <= den_mag;
			ovf_q <= (top_ext >= den_mag);
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], num_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

	`RBS_ASSERT(a_start_idle, start |-> !busy_q, "rbs_div: start while busy")
	`RBS_ASSERT(a_done_single, done_q |=> !done_q, "rbs_div: done held two cycles")
	`RBS_ASSERT_ALWAYS(a_done_not_busy, done_q |-> !busy_q, "rbs_div: done while busy")

endmodule

`default_nettype wire

[design/rbs_dp.sv]
// ------------------------------------------------------------------------
// rbs_dp
// Slab test datapath: request register, running interval, slab times
// through the shared divider, ordering, narrowing and result register.
// ------------------------------------------------------------------------
`default_nettype none

module rbs_dp
	import rbs_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ray_req_t req,
	input  wire rbs_cmd_t cmd,
	output rbs_sts_t      sts,
	output ray_res_t      res
);

	ray_req_t           item_q;
	logic signed [31:0] run_lo_q;
	logic signed [31:0] run_hi_q;
	logic [32:0]        diff_q;
	logic               neg_q;
	logic signed [31:0] t0_q;
	logic signed [31:0] near_q;
	logic signed [31:0] far_q;
	ray_res_t           res_q;

	logic signed [31:0] slab;
	logic [32:0]        diff;
	logic [32:0]        diff_abs;
	logic [31:0]        dir_mag;
	logic [31:0]        div_quo;
	logic               div_ovf;
	logic               div_busy;
	logic               div_done;
	logic signed [31:0] t_cur;
	logic               org_in_slab;

	function automatic logic signed [31:0] sat_time(
		input logic [31:0] q,
		input logic        ovf,
		input logic        neg
	);
		logic signed [31:0] r;
		if (neg) begin
			if (ovf || (q[31] && (|q[30:0]))) r = T_MIN;
			else r = $signed(~q + 32'd1);
		end else begin
			if (ovf || q[31]) r = T_MAX;
			else r = $signed(q);
		end
		return r;
	endfunction

	assign slab     = cmd.sel ? item_q.slab_max : item_q.slab_min;
	assign diff     = {slab[31], slab} - {item_q.axis_origin[31], item_q.axis_origin};
	assign diff_abs = diff_q[32] ? (~diff_q + 33'd1) : diff_q;
	assign dir_mag  = item_q.axis_direction[31] ? (~item_q.axis_direction + 32'd1)
		: item_q.axis_direction;

	rbs_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.num_mag (diff_abs[31:0]),
		.den_mag (dir_mag),
		.busy    (div_busy),
		.done    (div_done),
		.quo     (div_quo),
		.ovf     (div_ovf)
	);

	assign t_cur       = sat_time(div_quo, div_ovf, neg_q);
	assign org_in_slab = (item_q.slab_min < item_q.axis_origin)
		&& (item_q.axis_origin < item_q.slab_max);

	// running interval is architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_lo_q <= '0;
			run_hi_q <= '0;
		end else begin
			if (cmd.load) begin
				if (req.first_axis) begin
					run_lo_q <= req.start_t_min;
					run_hi_q <= req.start_t_max;
				end
			end else if (cmd.narrow) begin
				if (sts.dir_zero) begin
					// origin on or outside the slab empties the interval
					if (!org_in_slab) begin
						run_lo_q <= T_MAX;
						run_hi_q <= T_MIN;
					end
				end else begin
					if (near_q > run_lo_q) run_lo_q <= near_q;
					if (far_q < run_hi_q) run_hi_q <= far_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= req;
		if (cmd.prep) begin
			diff_q <= diff;
			neg_q  <= diff[32] ^ item_q.axis_direction[31];
		end
		if (cmd.save_t0) t0_q <= t_cur;
		if (cmd.order) begin
			if (t0_q < t_cur) begin
				near_q <= t0_q;
				far_q  <= t_cur;
			end else begin
				near_q <= t_cur;
				far_q  <= t0_q;
			end
		end
		if (cmd.finish) begin
			res_q.still_hit  <= (run_hi_q > run_lo_q);
			res_q.done_res   <= item_q.last_axis;
			res_q.enter_time <= run_lo_q;
			res_q.exit_time  <= run_hi_q;
		end
	end

	assign sts = '{
		dir_zero: (item_q.axis_direction == 32'sd0),
		div_done: (div_done && !div_busy)
	};
	assign res = res_q;

endmodule

`default_nettype wire

[design/rbs_ctrl.sv]
// ------------------------------------------------------------------------
// rbs_ctrl
// Slab test controller: sequences the two slab divisions, ordering,
// narrowing and the result handoff, and owns both handshakes.
// ------------------------------------------------------------------------
`default_nettype none
`include "ray_box_slab_test_defines.svh"

module rbs_ctrl
	import rbs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output logic          res_valid,
	input  wire logic     res_stall,
	output rbs_cmd_t      cmd,
	input  wire rbs_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_WAIT,
		ST_ORDER,
		ST_NARROW,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   sel_q;
	logic   res_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.sel  = sel_q;
		cmd.load = req_valid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE:   ;
			ST_PREP:   cmd.prep = 1'b1;
			ST_START:  cmd.div_start = 1'b1;
			ST_WAIT:   cmd.save_t0 = sts.div_done && !sel_q;
			ST_ORDER:  cmd.order = 1'b1;
			ST_NARROW: cmd.narrow = 1'b1;
			ST_FINISH: cmd.finish = !res_valid_q || !res_stall;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			priority if (cmd.finish) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			else res_valid_q <= res_valid_q;

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						sel_q   <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= sts.dir_zero ? ST_NARROW : ST_START;
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sts.div_done) begin
						if (!sel_q) begin
							// advance to the upper slab
							sel_q   <= 1'b1;
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_ORDER;
						end
					end
				end
				ST_ORDER:  state_q <= ST_NARROW;
				ST_NARROW: state_q <= ST_FINISH;
				ST_FINISH: begin
					// hold until the result register frees up
					if (cmd.finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	`RBS_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.prep, cmd.div_start, cmd.save_t0, cmd.order, cmd.narrow, cmd.finish}), "rbs_ctrl: overlapping commands")
	`RBS_ASSERT(a_no_overwrite, cmd.finish |-> !(res_valid_q && res_stall), "rbs_ctrl: result overwritten while stalled")
	`RBS_ASSERT(a_accept_prep, (req_valid && !req_stall) |=> (state_q == ST_PREP), "rbs_ctrl: accepted request not started")

endmodule

`default_nettype wire

[design/ray_box_slab_test.sv]
// ------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box slab test in signed fixed point, one axis
// per request, narrowing a running ray parameter interval.
//
// Channels: req (ray_req_t) with req_valid/req_stall, res (ray_res_t) with
// res_valid/res_stall; a transfer happens when valid is high and stall low.
// Each request yields exactly one result. first_axis reloads the interval
// from start_t_min/start_t_max; otherwise the interval left by the previous
// request is narrowed.
// Sequence: a request with nonzero direction runs two 32-step passes of
// the single serial divider (slab_min time, then slab_max time), each
// after a setup and a start step, then ordering, narrowing and result
// load. req_stall stays high until the request has finished; a zero
// direction skips the divider and the ordering.
// Reset clears the running interval to [0, 0] and empties the result
// register. A stalled result stays in its register while the next request
// is accepted and processed; that request then waits in its final step
// until the register is taken.
// ------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test
	import rbs_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire ray_req_t req,
	output logic          res_valid,
	input  wire logic     res_stall,
	output ray_res_t      res
);

	rbs_cmd_t cmd;
	rbs_sts_t sts;

	rbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rbs_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

`default_nettype wire
